>>> design/ugs_pkg.sv
`timescale 1ns / 1ps
// Shared widths, command codes and status codes for the undirected graph store.
// No dependencies; imported by the store top level.
package ugs_pkg;

    // Field widths
    localparam int ID_W  = 32;
    localparam int CMD_W = 3;
    localparam int ST_W  = 3;

    // Default slot count
    localparam int MAX_VERTICES_DEF = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD_V  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_E  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DROP_V = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DROP_E = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LIST   = 3'd5;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_EXISTS  = 3'd1;
    localparam logic [ST_W-1:0] ST_MISSING = 3'd2;
    localparam logic [ST_W-1:0] ST_SELF    = 3'd3;
    localparam logic [ST_W-1:0] ST_NO_EDGE = 3'd4;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd5;

endpackage

>>> design/undirected_graph_store_top.sv
`timescale 1ns / 1ps
// Undirected graph store: slots of ids plus a symmetric adjacency bit matrix.
// Depends on ugs_pkg and ugs_ram (id store and adjacency row store).
// Lookup scans the id RAM one slot a cycle, checking both ends and the lowest free slot;
// edge commands then read and rewrite both rows, and dropping a vertex adds a sweep over every row.
// Listing reads the first end's row, then makes one id-RAM pass per neighbour.
// One command at a time; the input is stalled until the last result sits in the output register.
// Synchronous active-low reset empties the graph at once through per-slot and per-row valid bits.
module undirected_graph_store_top
    import ugs_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Command channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic signed [ID_W-1:0]  i_vertex_a,
    input  logic signed [ID_W-1:0]  i_vertex_b,
    // Result channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [ST_W-1:0]         o_status,
    output logic signed [ID_W-1:0]  o_neighbour_id,
    output logic                    o_neighbour_valid,
    output logic                    o_last
);

    localparam int W_IDX = $clog2(MAX_VERTICES);
    localparam logic [W_IDX-1:0] LAST_IDX = W_IDX'(MAX_VERTICES - 1);

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FIND     = 4'd1;
    localparam logic [3:0] S_DECIDE   = 4'd2;
    localparam logic [3:0] S_E_RD_A   = 4'd3;
    localparam logic [3:0] S_E_WR_A   = 4'd4;
    localparam logic [3:0] S_E_WR_B   = 4'd5;
    localparam logic [3:0] S_SWEEP    = 4'd6;
    localparam logic [3:0] S_LROW     = 4'd7;
    localparam logic [3:0] S_LROW_Q   = 4'd8;
    localparam logic [3:0] S_LIST     = 4'd9;
    localparam logic [3:0] S_PASS_END = 4'd10;
    localparam logic [3:0] S_EMIT     = 4'd11;

    // Control state
    logic [3:0]              r_state, n_state;
    logic                    r_issuing, n_issuing;
    logic [W_IDX-1:0]        r_scan_idx, n_scan_idx;
    logic                    r_chk_vld, n_chk_vld;
    logic [W_IDX-1:0]        r_chk_idx, n_chk_idx;
    logic [MAX_VERTICES-1:0] r_used, n_used;
    logic [MAX_VERTICES-1:0] r_row_vld, n_row_vld;
    logic                    r_o_valid, n_o_valid;

    // Command and lookup results
    logic [CMD_W-1:0]        r_cmd, n_cmd;
    logic [ID_W-1:0]         r_a, n_a;
    logic [ID_W-1:0]         r_b, n_b;
    logic                    r_fa, n_fa;
    logic                    r_fb, n_fb;
    logic [W_IDX-1:0]        r_sa, n_sa;
    logic [W_IDX-1:0]        r_sb, n_sb;
    logic                    r_free_ok, n_free_ok;
    logic [W_IDX-1:0]        r_free, n_free;
    logic [W_IDX-1:0]        r_rd_idx, n_rd_idx;

    // Listing
    logic [MAX_VERTICES-1:0] r_row, n_row;
    logic                    r_have_prev, n_have_prev;
    logic [ID_W-1:0]         r_prev, n_prev;
    logic [ID_W-1:0]         r_min, n_min;
    logic [1:0]              r_cnt, n_cnt;

    // Pending result and output register
    logic [ST_W-1:0]         r_res_status, n_res_status;
    logic [ID_W-1:0]         r_res_id, n_res_id;
    logic                    r_res_nv, n_res_nv;
    logic                    r_res_last, n_res_last;
    logic [ST_W-1:0]         r_o_status, n_o_status;
    logic [ID_W-1:0]         r_o_id, n_o_id;
    logic                    r_o_nv, n_o_nv;
    logic                    r_o_last, n_o_last;

    // RAM ports
    logic                    id_we, id_re;
    logic [W_IDX-1:0]        id_waddr, id_raddr;
    logic [ID_W-1:0]         id_wdata, id_q;
    logic                    adj_we, adj_re;
    logic [W_IDX-1:0]        adj_waddr, adj_raddr;
    logic [MAX_VERTICES-1:0] adj_wdata, adj_q;

    logic                    in_xfer;
    logic                    can_load;
    logic [MAX_VERTICES-1:0] row_eff;
    logic                    cand;

    ugs_ram #(.WIDTH(ID_W), .DEPTH(MAX_VERTICES)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (id_waddr),
        .i_wdata (id_wdata),
        .i_re    (id_re),
        .i_raddr (id_raddr),
        .o_rdata (id_q)
    );

    ugs_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_re    (adj_re),
        .i_raddr (adj_raddr),
        .o_rdata (adj_q)
    );

    assign o_in_stall        = (r_state != S_IDLE);
    assign in_xfer           = i_in_valid && !o_in_stall;
    assign can_load          = !r_o_valid || !i_out_stall;
    assign o_out_valid       = r_o_valid;
    assign o_status          = r_o_status;
    assign o_neighbour_id    = r_o_id;
    assign o_neighbour_valid = r_o_nv;
    assign o_last            = r_o_last;

    // A row never written since its slot was taken reads as empty
    assign row_eff = r_row_vld[r_rd_idx] ? adj_q : '0;

    // Listing candidate: used neighbour above the last one sent
    assign cand = r_used[r_chk_idx] && r_row[r_chk_idx] && (r_chk_idx != r_sa) &&
                  (!r_have_prev || ($signed(id_q) > $signed(r_prev)));

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_issuing    = r_issuing;
        n_scan_idx   = r_scan_idx;
        n_used       = r_used;
        n_row_vld    = r_row_vld;
        n_cmd        = r_cmd;
        n_a          = r_a;
        n_b          = r_b;
        n_fa         = r_fa;
        n_fb         = r_fb;
        n_sa         = r_sa;
        n_sb         = r_sb;
        n_free_ok    = r_free_ok;
        n_free       = r_free;
        n_row        = r_row;
        n_have_prev  = r_have_prev;
        n_prev       = r_prev;
        n_min        = r_min;
        n_cnt        = r_cnt;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_nv     = r_res_nv;
        n_res_last   = r_res_last;
        n_o_valid    = r_o_valid;
        n_o_status   = r_o_status;
        n_o_id       = r_o_id;
        n_o_nv       = r_o_nv;
        n_o_last     = r_o_last;

        id_we     = 1'b0;
        id_waddr  = r_free;
        id_wdata  = r_a;
        id_re     = r_issuing && ((r_state == S_FIND) || (r_state == S_LIST));
        id_raddr  = r_scan_idx;
        adj_we    = 1'b0;
        adj_waddr = r_rd_idx;
        adj_wdata = row_eff;
        adj_re    = r_issuing && (r_state == S_SWEEP);
        adj_raddr = r_scan_idx;

        // Slot scan counter, one read a cycle
        if (id_re || adj_re) begin
            if (r_scan_idx == LAST_IDX) begin
                n_issuing = 1'b0;
            end else begin
                n_scan_idx = r_scan_idx + W_IDX'(1);
            end
        end

        // Output register drains on transfer
        if (r_o_valid && !i_out_stall) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cmd        = i_cmd;
                    n_a          = i_vertex_a;
                    n_b          = i_vertex_b;
                    n_fa         = 1'b0;
                    n_fb         = 1'b0;
                    n_free_ok    = 1'b0;
                    n_res_status = ST_OK;
                    n_res_id     = '0;
                    n_res_nv     = 1'b0;
                    n_res_last   = 1'b1;
                    priority if (i_cmd == CMD_CLEAR) begin
                        n_used    = '0;
                        n_row_vld = '0;
                        n_state   = S_EMIT;
                    end else if (i_cmd == CMD_ADD_E && i_vertex_a == i_vertex_b) begin
                        n_res_status = ST_SELF;
                        n_state      = S_EMIT;
                    end else if (i_cmd == CMD_ADD_V || i_cmd == CMD_ADD_E ||
                                 i_cmd == CMD_DROP_V || i_cmd == CMD_DROP_E ||
                                 i_cmd == CMD_LIST) begin
                        n_scan_idx = '0;
                        n_issuing  = 1'b1;
                        n_state    = S_FIND;
                    end else begin
                        // unused codes answer ok
                        n_state = S_EMIT;
                    end
                end
            end

            // Id lookup of both ends and lowest free slot
            S_FIND: begin
                if (r_chk_vld) begin
                    if (r_used[r_chk_idx] && id_q == r_a) begin
                        n_fa = 1'b1;
                        n_sa = r_chk_idx;
                    end
                    if (r_used[r_chk_idx] && id_q == r_b) begin
                        n_fb = 1'b1;
                        n_sb = r_chk_idx;
                    end
                    if (!r_used[r_chk_idx] && !r_free_ok) begin
                        n_free_ok = 1'b1;
                        n_free    = r_chk_idx;
                    end
                    if (r_chk_idx == LAST_IDX) begin
                        n_state = S_DECIDE;
                    end
                end
            end

            S_DECIDE: begin
                n_state = S_EMIT;
                unique case (r_cmd)
                    CMD_ADD_V: begin
                        priority if (r_fa) begin
                            n_res_status = ST_EXISTS;
                        end else if (!r_free_ok) begin
                            n_res_status = ST_FULL;
                        end else begin
                            id_we             = 1'b1;
                            n_used[r_free]    = 1'b1;
                            n_row_vld[r_free] = 1'b0;
                        end
                    end
                    CMD_ADD_E, CMD_DROP_E: begin
                        if (!r_fa || !r_fb) begin
                            n_res_status = ST_MISSING;
                        end else begin
                            n_state = S_E_RD_A;
                        end
                    end
                    CMD_DROP_V: begin
                        if (!r_fa) begin
                            n_res_status = ST_MISSING;
                        end else begin
                            n_scan_idx = '0;
                            n_issuing  = 1'b1;
                            n_state    = S_SWEEP;
                        end
                    end
                    default: begin
                        // listing
                        if (!r_fa) begin
                            n_res_status = ST_MISSING;
                        end else begin
                            n_state = S_LROW;
                        end
                    end
                endcase
            end

            S_E_RD_A: begin
                adj_re    = 1'b1;
                adj_raddr = r_sa;
                n_state   = S_E_WR_A;
            end

            // Row of the first end: check the edge bit, then update
            S_E_WR_A: begin
                priority if (r_cmd == CMD_ADD_E && row_eff[r_sb]) begin
                    n_res_status = ST_EXISTS;
                    n_state      = S_EMIT;
                end else if (r_cmd == CMD_DROP_E && !row_eff[r_sb]) begin
                    n_res_status = ST_NO_EDGE;
                    n_state      = S_EMIT;
                end else begin
                    adj_we            = 1'b1;
                    adj_waddr         = r_sa;
                    adj_wdata[r_sb]   = (r_cmd == CMD_ADD_E);
                    n_row_vld[r_sa]   = 1'b1;
                    adj_re            = 1'b1;
                    adj_raddr         = r_sb;
                    n_state           = S_E_WR_B;
                end
            end

            // Mirror bit in the row of the second end
            S_E_WR_B: begin
                adj_we          = 1'b1;
                adj_waddr       = r_sb;
                adj_wdata[r_sa] = (r_cmd == CMD_ADD_E);
                n_row_vld[r_sb] = 1'b1;
                n_state         = S_EMIT;
            end

            // Clear the dropped slot's column in every row
            S_SWEEP: begin
                if (r_chk_vld) begin
                    adj_we          = 1'b1;
                    adj_waddr       = r_chk_idx;
                    adj_wdata[r_sa] = 1'b0;
                    if (r_chk_idx == LAST_IDX) begin
                        n_used[r_sa]    = 1'b0;
                        n_row_vld[r_sa] = 1'b0;
                        n_state         = S_EMIT;
                    end
                end
            end

            S_LROW: begin
                adj_re    = 1'b1;
                adj_raddr = r_sa;
                n_state   = S_LROW_Q;
            end

            S_LROW_Q: begin
                n_row       = row_eff;
                n_have_prev = 1'b0;
                n_cnt       = '0;
                n_scan_idx  = '0;
                n_issuing   = 1'b1;
                n_state     = S_LIST;
            end

            // One pass: smallest neighbour above the previous one
            S_LIST: begin
                if (r_chk_vld) begin
                    if (cand) begin
                        if (r_cnt == 2'd0 || $signed(id_q) < $signed(r_min)) begin
                            n_min = id_q;
                        end
                        if (r_cnt != 2'd2) begin
                            n_cnt = r_cnt + 2'd1;
                        end
                    end
                    if (r_chk_idx == LAST_IDX) begin
                        n_state = S_PASS_END;
                    end
                end
            end

            S_PASS_END: begin
                n_res_status = ST_OK;
                if (r_cnt == 2'd0) begin
                    n_res_id   = '0;
                    n_res_nv   = 1'b0;
                    n_res_last = 1'b1;
                end else begin
                    n_res_id    = r_min;
                    n_res_nv    = 1'b1;
                    n_res_last  = (r_cnt == 2'd1);
                    n_prev      = r_min;
                    n_have_prev = 1'b1;
                end
                n_state = S_EMIT;
            end

            S_EMIT: begin
                if (can_load) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_id     = r_res_id;
                    n_o_nv     = r_res_nv;
                    n_o_last   = r_res_last;
                    if (r_res_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt      = '0;
                        n_scan_idx = '0;
                        n_issuing  = 1'b1;
                        n_state    = S_LIST;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Read pipeline tracking
    assign n_chk_vld = id_re || adj_re;
    assign n_chk_idx = r_scan_idx;
    assign n_rd_idx  = adj_re ? adj_raddr : r_rd_idx;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issuing <= 1'b0;
            r_chk_vld <= 1'b0;
            r_used    <= '0;
            r_row_vld <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issuing <= n_issuing;
            r_chk_vld <= n_chk_vld;
            r_used    <= n_used;
            r_row_vld <= n_row_vld;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_scan_idx   <= n_scan_idx;
        r_chk_idx    <= n_chk_idx;
        r_rd_idx     <= n_rd_idx;
        r_cmd        <= n_cmd;
        r_a          <= n_a;
        r_b          <= n_b;
        r_fa         <= n_fa;
        r_fb         <= n_fb;
        r_sa         <= n_sa;
        r_sb         <= n_sb;
        r_free_ok    <= n_free_ok;
        r_free       <= n_free;
        r_row        <= n_row;
        r_have_prev  <= n_have_prev;
        r_prev       <= n_prev;
        r_min        <= n_min;
        r_cnt        <= n_cnt;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_nv     <= n_res_nv;
        r_res_last   <= n_res_last;
        r_o_status   <= n_o_status;
        r_o_id       <= n_o_id;
        r_o_nv       <= n_o_nv;
        r_o_last     <= n_o_last;
    end

    // A new vertex only ever lands in an empty slot
    a_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        id_we |-> !r_used[id_waddr])
        else $error("vertex written over a used slot");

    // Clear has emptied every slot in the cycle after it is accepted
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_cmd == CMD_CLEAR) |=> (r_used == '0 && r_row_vld == '0))
        else $error("clear left slots in use");

    // A pending result is held while the output register is blocked
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_o_valid && i_out_stall) |=> (r_state == S_EMIT))
        else $error("result lost behind a stalled output");

    // Scan index stays within the slot range
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issuing |-> (r_scan_idx <= LAST_IDX))
        else $error("scan index out of range");

    // The edge checks never see a self edge stored
    a_no_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adj_we && r_state == S_E_WR_A) |-> (r_sa != r_sb || r_cmd == CMD_DROP_E))
        else $error("self edge written");

endmodule

>>> design/ugs_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ugs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
